### sv/bmap_pkg.sv
// ----------------------------------------------------------------------------
// bmap_pkg
// Shared constants, command codes and helpers of the bitmap allocator.
// ----------------------------------------------------------------------------
package bmap_pkg;

  localparam int BITMAP_WORDS = 256;
  localparam int WORD_BITS    = 32;
  localparam int ADDR_W       = $clog2(BITMAP_WORDS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int IDX_W        = ADDR_W + BIT_W;
  localparam int ONES_W       = IDX_W + 1;
  localparam int POP_W        = BIT_W + 1;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;

  localparam logic [MODE_W-1:0] MODE_FIND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GET   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    OP_FIND,
    OP_SET,
    OP_CLR,
    OP_GET,
    OP_COUNT,
    OP_LOAD,
    OP_RANGE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [ADDR_W-1:0]    word;
    logic [BIT_W-1:0]     bitpos;
    logic [WORD_BITS-1:0] data;
    logic [CNT_W-1:0]     nact;
  } cmd_t;

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    v = w - ((w >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0F0F_0F0F;
    v = v + (v >> 8);
    v = v + (v >> 16);
    return v[POP_W-1:0];
  endfunction

endpackage

### sv/bmap_front.sv
// ----------------------------------------------------------------------------
// bmap_front
// Holds the words-in-use register, decodes requests, range checks them and
// pushes commands into the queue.
// ----------------------------------------------------------------------------
module bmap_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bmap_pkg::CNT_W-1:0]           words_in_use_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bmap_pkg::MODE_W-1:0]          mode_i,
  input  logic [bmap_pkg::IDX_W-1:0]           bit_index_i,
  input  logic [bmap_pkg::ADDR_W-1:0]          word_index_i,
  input  logic [bmap_pkg::WORD_BITS-1:0]       word_data_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output bmap_pkg::cmd_t                       q_cmd_o
);

  localparam logic [bmap_pkg::CNT_W-1:0] WORDS_N = bmap_pkg::CNT_W'(bmap_pkg::BITMAP_WORDS);

  logic [bmap_pkg::CNT_W-1:0]  wiu_q;
  logic [bmap_pkg::CNT_W-1:0]  nact;
  logic [bmap_pkg::ADDR_W-1:0] bit_word;
  logic                        bit_oor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= WORDS_N;
    end else if (cfg_valid_i) begin
      wiu_q <= words_in_use_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  assign nact     = (wiu_q > WORDS_N) ? WORDS_N : wiu_q;
  assign bit_word = bit_index_i[bmap_pkg::IDX_W-1:bmap_pkg::BIT_W];
  assign bit_oor  = {1'b0, bit_word} >= nact;

  always_comb begin
    q_cmd_o.word   = bit_word;
    q_cmd_o.bitpos = bit_index_i[bmap_pkg::BIT_W-1:0];
    q_cmd_o.data   = word_data_i;
    q_cmd_o.nact   = nact;
    case (mode_i)
      bmap_pkg::MODE_FIND:  q_cmd_o.op = bmap_pkg::OP_FIND;
      bmap_pkg::MODE_SET:   q_cmd_o.op = bit_oor ? bmap_pkg::OP_RANGE : bmap_pkg::OP_SET;
      bmap_pkg::MODE_CLR:   q_cmd_o.op = bit_oor ? bmap_pkg::OP_RANGE : bmap_pkg::OP_CLR;
      bmap_pkg::MODE_GET:   q_cmd_o.op = bit_oor ? bmap_pkg::OP_RANGE : bmap_pkg::OP_GET;
      bmap_pkg::MODE_COUNT: q_cmd_o.op = bmap_pkg::OP_COUNT;
      bmap_pkg::MODE_LOAD: begin
        q_cmd_o.word = word_index_i;
        q_cmd_o.op   = ({1'b0, word_index_i} >= WORDS_N) ? bmap_pkg::OP_RANGE
                                                         : bmap_pkg::OP_LOAD;
      end
      default:              q_cmd_o.op = bmap_pkg::OP_NOP;
    endcase
  end

endmodule

### sv/bmap_queue.sv
// ----------------------------------------------------------------------------
// bmap_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bmap_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmap_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bmap_pkg::cmd_t cmd_o
);

  bmap_pkg::cmd_t ent_q [2];
  logic           wp_q;
  logic           rp_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = ent_q[rp_q];

endmodule

### sv/bmap_back.sv
// ----------------------------------------------------------------------------
// bmap_back
// Bitmap store and sequencer: word scans for find and count, read-modify-write
// for set and clear, a read for get, a write for load, and the result register.
// ----------------------------------------------------------------------------
module bmap_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  bmap_pkg::cmd_t                      q_cmd_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bmap_pkg::STATUS_W-1:0]       status_o,
  output logic [bmap_pkg::IDX_W-1:0]          found_bit_o,
  output logic                                bit_value_o,
  output logic [bmap_pkg::ONES_W-1:0]         ones_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FENC,
    S_RMW
  } state_e;

  state_e                         state_q;
  bmap_pkg::op_e                  op_q;
  logic [bmap_pkg::BIT_W-1:0]     bit_q;
  logic [bmap_pkg::ADDR_W-1:0]    addr_q;
  logic [bmap_pkg::CNT_W-1:0]     n_q;
  logic [bmap_pkg::CNT_W-1:0]     cnt_q;
  logic                           dv_q;
  logic [bmap_pkg::ADDR_W-1:0]    di_q;
  logic [bmap_pkg::ONES_W-1:0]    acc_q;
  logic [bmap_pkg::WORD_BITS-1:0] hit_word_q;
  logic [bmap_pkg::ADDR_W-1:0]    hit_idx_q;

  logic                           out_vld_q;
  logic [bmap_pkg::STATUS_W-1:0]  status_q;
  logic [bmap_pkg::IDX_W-1:0]     found_q;
  logic                           bval_q;
  logic [bmap_pkg::ONES_W-1:0]    ones_q;

  logic [bmap_pkg::WORD_BITS-1:0] mem [bmap_pkg::BITMAP_WORDS];
  logic [bmap_pkg::BITMAP_WORDS-1:0] vbits_q;
  logic [bmap_pkg::WORD_BITS-1:0] rd_data_q;
  logic                           rd_vld_q;

  logic                           pop;
  logic                           issue;
  logic [bmap_pkg::ADDR_W-1:0]    rd_addr;
  logic [bmap_pkg::WORD_BITS-1:0] rd_word;
  logic [bmap_pkg::WORD_BITS-1:0] mask;
  logic                           we;
  logic [bmap_pkg::ADDR_W-1:0]    wa;
  logic [bmap_pkg::WORD_BITS-1:0] wd;
  logic [bmap_pkg::BIT_W-1:0]     zpos;

  assign pop     = (state_q == S_IDLE) && q_valid_i && (!out_vld_q || out_ready_i);
  assign issue   = (state_q == S_SCAN) && (cnt_q < n_q);
  assign rd_addr = (state_q == S_IDLE) ? q_cmd_i.word : cnt_q[bmap_pkg::ADDR_W-1:0];
  assign rd_word = rd_vld_q ? rd_data_q : '0;
  assign mask    = bmap_pkg::WORD_BITS'(1) << bit_q;
  assign q_pop_o = pop;

  always_comb begin
    we = 1'b0;
    wa = addr_q;
    wd = rd_word | mask;
    if (pop && (q_cmd_i.op == bmap_pkg::OP_LOAD)) begin
      we = 1'b1;
      wa = q_cmd_i.word;
      wd = q_cmd_i.data;
    end else if (state_q == S_RMW) begin
      we = (op_q == bmap_pkg::OP_SET) || (op_q == bmap_pkg::OP_CLR);
      wd = (op_q == bmap_pkg::OP_SET) ? (rd_word | mask) : (rd_word & ~mask);
    end
  end

  always_comb begin
    zpos = '0;
    for (int k = bmap_pkg::WORD_BITS - 1; k >= 0; k--) begin
      if (!hit_word_q[k]) begin
        zpos = bmap_pkg::BIT_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbits_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vbits_q[wa] <= 1'b1;
      end
      rd_vld_q <= vbits_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= bmap_pkg::OP_NOP;
      bit_q      <= '0;
      addr_q     <= '0;
      n_q        <= '0;
      cnt_q      <= '0;
      dv_q       <= 1'b0;
      di_q       <= '0;
      acc_q      <= '0;
      hit_word_q <= '0;
      hit_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      status_q   <= bmap_pkg::ST_OK;
      found_q    <= '0;
      bval_q     <= 1'b0;
      ones_q     <= '0;
    end else begin
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            op_q   <= q_cmd_i.op;
            bit_q  <= q_cmd_i.bitpos;
            addr_q <= q_cmd_i.word;
            n_q    <= q_cmd_i.nact;
            cnt_q  <= '0;
            dv_q   <= 1'b0;
            acc_q  <= '0;
            case (q_cmd_i.op)
              bmap_pkg::OP_FIND, bmap_pkg::OP_COUNT: begin
                state_q <= S_SCAN;
              end
              bmap_pkg::OP_SET, bmap_pkg::OP_CLR, bmap_pkg::OP_GET: begin
                state_q <= S_RMW;
              end
              bmap_pkg::OP_RANGE: begin
                out_vld_q <= 1'b1;
                status_q  <= bmap_pkg::ST_RANGE;
                found_q   <= '0;
                bval_q    <= 1'b0;
                ones_q    <= '0;
              end
              default: begin
                out_vld_q <= 1'b1;
                status_q  <= bmap_pkg::ST_OK;
                found_q   <= '0;
                bval_q    <= 1'b0;
                ones_q    <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          dv_q <= issue;
          di_q <= cnt_q[bmap_pkg::ADDR_W-1:0];
          if (dv_q) begin
            if (op_q == bmap_pkg::OP_FIND) begin
              if (rd_word != '1) begin
                hit_word_q <= rd_word;
                hit_idx_q  <= di_q;
                state_q    <= S_FENC;
              end
            end else begin
              acc_q <= acc_q + bmap_pkg::ONES_W'(bmap_pkg::popcount(rd_word));
            end
          end else if (cnt_q == n_q) begin
            out_vld_q <= 1'b1;
            status_q  <= (op_q == bmap_pkg::OP_FIND) ? bmap_pkg::ST_FULL : bmap_pkg::ST_OK;
            found_q   <= '0;
            bval_q    <= 1'b0;
            ones_q    <= (op_q == bmap_pkg::OP_FIND) ? '0 : acc_q;
            state_q   <= S_IDLE;
          end
        end
        S_FENC: begin
          out_vld_q <= 1'b1;
          status_q  <= bmap_pkg::ST_OK;
          found_q   <= {hit_idx_q, zpos};
          bval_q    <= 1'b0;
          ones_q    <= '0;
          state_q   <= S_IDLE;
        end
        S_RMW: begin
          out_vld_q <= 1'b1;
          status_q  <= bmap_pkg::ST_OK;
          found_q   <= '0;
          bval_q    <= (op_q == bmap_pkg::OP_GET) ? rd_word[bit_q] : 1'b0;
          ones_q    <= '0;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = status_q;
  assign found_bit_o  = found_q;
  assign bit_value_o  = bval_q;
  assign ones_count_o = ones_q;

endmodule

### sv/bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_allocator_unit
// Free-space bitmap allocator: find lowest clear bit, set/clear/get a bit,
// count set bits, load a word.
//
//   channel  dir  handshake                 word
//   cfg      in   cfg_valid_i/cfg_ready_o   words_in_use_i
//   in       in   in_valid_i/in_ready_o     mode, bit_index, word_index, word_data
//   out      out  out_valid_o/out_ready_i   status, found_bit, bit_value, ones_count
//
// Back end per request: load, unused mode and out of range go straight to the
// result register; set/clear/get read the word, then set/clear write it back;
// count reads n words and find up to n, n = words in use, one word per cycle.
// Reset: store reads as zero through per-word valid bits; no clearing pass.
// A two-entry queue lets requests enter while the back end is busy or a
// result waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bmap_pkg::CNT_W-1:0]          words_in_use_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bmap_pkg::MODE_W-1:0]         mode_i,
  input  logic [bmap_pkg::IDX_W-1:0]          bit_index_i,
  input  logic [bmap_pkg::ADDR_W-1:0]         word_index_i,
  input  logic [bmap_pkg::WORD_BITS-1:0]      word_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bmap_pkg::STATUS_W-1:0]       status_o,
  output logic [bmap_pkg::IDX_W-1:0]          found_bit_o,
  output logic                                bit_value_o,
  output logic [bmap_pkg::ONES_W-1:0]         ones_count_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  bmap_pkg::cmd_t cmd_in;
  bmap_pkg::cmd_t cmd_out;

  bmap_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .words_in_use_i (words_in_use_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .bit_index_i    (bit_index_i),
    .word_index_i   (word_index_i),
    .word_data_i    (word_data_i),
    .q_full_i       (full),
    .q_push_o       (push),
    .q_cmd_o        (cmd_in)
  );

  bmap_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  bmap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (cmd_out),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_bit_o  (found_bit_o),
    .bit_value_o  (bit_value_o),
    .ones_count_o (ones_count_o)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_allocator_unit. Requests go in on a
// valid/ready channel with random gaps. A local bitmap copy predicts every
// result, and results are checked field by field in order. The bench covers
// directed corner cases, a long output stall and random allocate/free, fill
// and mixed traffic across several words-in-use settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bmap_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [bmap_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [bmap_pkg::STATUS_W-1:0] status;
    logic [bmap_pkg::IDX_W-1:0]    found_bit;
    logic                          bit_value;
    logic [bmap_pkg::ONES_W-1:0]   ones_count;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bmap_pkg::CNT_W-1:0]     cfg_words = '0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [bmap_pkg::MODE_W-1:0]    req_mode = '0;
  logic [bmap_pkg::IDX_W-1:0]     req_bit = '0;
  logic [bmap_pkg::ADDR_W-1:0]    req_word = '0;
  logic [bmap_pkg::WORD_BITS-1:0] req_data = '0;

  logic                           out_valid;
  logic                           rx_ready = 1'b0;
  logic                           rx_hold = 1'b0;
  wire                            out_ready = rx_ready & ~rx_hold;
  logic [bmap_pkg::STATUS_W-1:0]  res_status;
  logic [bmap_pkg::IDX_W-1:0]     res_found;
  logic                           res_bitval;
  logic [bmap_pkg::ONES_W-1:0]    res_ones;

  // bitmap copy and register copy
  logic [bmap_pkg::WORD_BITS-1:0] bm_model [bmap_pkg::BITMAP_WORDS] = '{default: '0};
  logic [bmap_pkg::CNT_W-1:0]     words_cfg = 9'd256;

  alloc_result_t pending_results [$];
  int  err_cnt = 0;
  int  reqs_sent = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  bit  req_offered = 1'b0;
  bit  rx_on = 1'b0;
  event hold_kick;

  bitmap_allocator_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .words_in_use_i (cfg_words),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (req_mode),
    .bit_index_i    (req_bit),
    .word_index_i   (req_word),
    .word_data_i    (req_data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (res_status),
    .found_bit_o    (res_found),
    .bit_value_o    (res_bitval),
    .ones_count_o   (res_ones)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_words();
    return (words_cfg > bmap_pkg::BITMAP_WORDS) ? bmap_pkg::BITMAP_WORDS
                                                : int'(words_cfg);
  endfunction

  function automatic alloc_result_t bitmap_predict(
      input logic [bmap_pkg::MODE_W-1:0] m, input logic [bmap_pkg::IDX_W-1:0] b,
      input logic [bmap_pkg::ADDR_W-1:0] w, input logic [bmap_pkg::WORD_BITS-1:0] d);
    alloc_result_t r;
    int n, i, j, wi;
    r  = '0;
    n  = active_words();
    wi = int'(b[bmap_pkg::IDX_W-1:bmap_pkg::BIT_W]);
    case (m)
      bmap_pkg::MODE_FIND: begin
        i = 0;
        while (i < n && bm_model[i] == '1) i++;
        if (i == n) begin
          r.status = bmap_pkg::ST_FULL;
        end else begin
          j = 0;
          while (bm_model[i][j]) j++;
          r.found_bit = bmap_pkg::IDX_W'(i * bmap_pkg::WORD_BITS + j);
        end
      end
      bmap_pkg::MODE_SET, bmap_pkg::MODE_CLR, bmap_pkg::MODE_GET: begin
        if (wi >= n) r.status = bmap_pkg::ST_RANGE;
        else if (m == bmap_pkg::MODE_SET) bm_model[wi][b[bmap_pkg::BIT_W-1:0]] = 1'b1;
        else if (m == bmap_pkg::MODE_CLR) bm_model[wi][b[bmap_pkg::BIT_W-1:0]] = 1'b0;
        else r.bit_value = bm_model[wi][b[bmap_pkg::BIT_W-1:0]];
      end
      bmap_pkg::MODE_COUNT: begin
        for (i = 0; i < n; i++)
          r.ones_count += bmap_pkg::ONES_W'($countones(bm_model[i]));
      end
      bmap_pkg::MODE_LOAD: begin
        if (int'(w) < bmap_pkg::BITMAP_WORDS) bm_model[w] = d;
        else r.status = bmap_pkg::ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [bmap_pkg::IDX_W-1:0] pick_bit();
    int lim;
    lim = active_words() * bmap_pkg::WORD_BITS;
    case ($urandom_range(0, 7))
      0, 1: return bmap_pkg::IDX_W'($urandom_range(0, 8191));
      2: return bmap_pkg::IDX_W'(lim);
      default: return (lim > 0) ? bmap_pkg::IDX_W'($urandom_range(0, lim - 1))
                                : bmap_pkg::IDX_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [bmap_pkg::ADDR_W-1:0] pick_word();
    int n;
    n = active_words();
    if (n > 0 && $urandom_range(0, 3) != 0)
      return bmap_pkg::ADDR_W'($urandom_range(0, n - 1));
    return bmap_pkg::ADDR_W'($urandom_range(0, bmap_pkg::BITMAP_WORDS - 1));
  endfunction

  function automatic logic [bmap_pkg::WORD_BITS-1:0] pick_data();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return ~(32'd1 << $urandom_range(0, 31));
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic tx_stop();
    if (req_offered) begin
      in_valid <= 1'b0;
      req_offered = 1'b0;
    end
  endtask

  task automatic send_req(input logic [bmap_pkg::MODE_W-1:0] m,
                          input logic [bmap_pkg::IDX_W-1:0] b,
                          input logic [bmap_pkg::ADDR_W-1:0] w,
                          input logic [bmap_pkg::WORD_BITS-1:0] d,
                          output alloc_result_t want);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      tx_stop();
      repeat (gap) @(posedge clk);
    end
    if (!req_offered) in_valid <= 1'b1;
    req_offered = 1'b1;
    req_mode <= m;
    req_bit  <= b;
    req_word <= w;
    req_data <= d;
    do @(posedge clk); while (!in_ready);
    want = bitmap_predict(m, b, w, d);
    pending_results.push_back(want);
    reqs_sent++;
  endtask

  task automatic wait_idle();
    tx_stop();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_words_in_use(input logic [bmap_pkg::CNT_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_words <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    words_cfg = v;
  endtask

  task automatic run_mixed(input int cnt);
    alloc_result_t r;
    logic [bmap_pkg::MODE_W-1:0] m;
    repeat (cnt) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:    m = bmap_pkg::MODE_FIND;
        4, 5, 6, 7:    m = bmap_pkg::MODE_SET;
        8, 9, 10:      m = bmap_pkg::MODE_CLR;
        11, 12, 13:    m = bmap_pkg::MODE_GET;
        14, 15:        m = bmap_pkg::MODE_COUNT;
        16, 17, 18:    m = bmap_pkg::MODE_LOAD;
        default:       m = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
      endcase
      send_req(m, pick_bit(), pick_word(), pick_data(), r);
    end
  endtask

  // allocate lowest free bit, free random held bits
  task automatic run_alloc_free(input int rounds);
    alloc_result_t r;
    logic [bmap_pkg::IDX_W-1:0] held [$];
    int k;
    repeat (rounds) begin
      if (held.size() == 0 || $urandom_range(0, 2) != 0) begin
        send_req(bmap_pkg::MODE_FIND, pick_bit(), pick_word(), pick_data(), r);
        if (r.status == bmap_pkg::ST_OK) begin
          held.push_back(r.found_bit);
          send_req(bmap_pkg::MODE_SET, r.found_bit, pick_word(), pick_data(), r);
        end
      end else begin
        k = $urandom_range(0, held.size() - 1);
        send_req(bmap_pkg::MODE_CLR, held[k], pick_word(), pick_data(), r);
        held.delete(k);
      end
    end
    send_req(bmap_pkg::MODE_COUNT, pick_bit(), pick_word(), pick_data(), r);
  endtask

  task automatic run_fill();
    alloc_result_t r;
    int n;
    n = active_words();
    for (int i = 0; i < n; i++)
      send_req(bmap_pkg::MODE_LOAD, pick_bit(), bmap_pkg::ADDR_W'(i), '1, r);
    if (n > 0 && $urandom_range(0, 1) != 0)
      send_req(bmap_pkg::MODE_LOAD, pick_bit(),
               bmap_pkg::ADDR_W'($urandom_range(0, n - 1)),
               ~(32'd1 << $urandom_range(0, 31)), r);
    send_req(bmap_pkg::MODE_FIND, pick_bit(), pick_word(), pick_data(), r);
    send_req(bmap_pkg::MODE_COUNT, pick_bit(), pick_word(), pick_data(), r);
    send_req(bmap_pkg::MODE_GET, pick_bit(), pick_word(), pick_data(), r);
  endtask

  task automatic test_empty_bitmap();
    alloc_result_t r;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_req(bmap_pkg::MODE_FIND, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_COUNT, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_GET, 13'd8191, '1, '1, r);
  endtask

  task automatic test_bit_ops();
    alloc_result_t r;
    send_req(bmap_pkg::MODE_LOAD, '0, 8'd0, '1, r);
    send_req(bmap_pkg::MODE_LOAD, '0, 8'd255, 32'h8000_0001, r);
    send_req(bmap_pkg::MODE_FIND, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_SET, 13'd63, '0, '0, r);
    send_req(bmap_pkg::MODE_GET, 13'd63, '0, '0, r);
    send_req(bmap_pkg::MODE_CLR, 13'd0, '0, '0, r);
    send_req(bmap_pkg::MODE_FIND, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_CLR, 13'd8191, '0, '0, r);
    send_req(bmap_pkg::MODE_COUNT, '0, '0, '0, r);
  endtask

  task automatic test_spare_modes();
    alloc_result_t r;
    send_req(MODE_SPARE6, '1, '1, '1, r);
    send_req(MODE_SPARE7, '0, '0, '0, r);
  endtask

  task automatic test_no_words();
    alloc_result_t r;
    write_words_in_use(9'd0);
    send_req(bmap_pkg::MODE_FIND, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_SET, 13'd0, '0, '0, r);
    send_req(bmap_pkg::MODE_GET, 13'd0, '0, '0, r);
    send_req(bmap_pkg::MODE_COUNT, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_LOAD, '0, 8'd200, 32'hA5A5_5A5A, r);
  endtask

  task automatic test_one_word_full();
    alloc_result_t r;
    write_words_in_use(9'd1);
    send_req(bmap_pkg::MODE_LOAD, '0, 8'd0, '1, r);
    send_req(bmap_pkg::MODE_FIND, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_SET, 13'd32, '0, '0, r);
    send_req(bmap_pkg::MODE_GET, 13'd31, '0, '0, r);
    send_req(bmap_pkg::MODE_COUNT, '0, '0, '0, r);
  endtask

  task automatic test_clamped_size();
    alloc_result_t r;
    write_words_in_use(9'd511);
    send_req(bmap_pkg::MODE_COUNT, '0, '0, '0, r);
    send_req(bmap_pkg::MODE_GET, 13'd8191, '0, '0, r);
  endtask

  task automatic test_output_stall();
    write_words_in_use(9'd2);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    -> hold_kick;
    run_mixed(24);
  endtask

  task automatic test_random_traffic(input int cnt);
    int target, n;
    target = reqs_sent + cnt;
    while (reqs_sent < target) begin
      case ($urandom_range(0, 9))
        0:          write_words_in_use(9'd0);
        1:          write_words_in_use(9'd1);
        2:          write_words_in_use(9'd256);
        3:          write_words_in_use(9'd511);
        4:          write_words_in_use(bmap_pkg::CNT_W'($urandom_range(257, 511)));
        5, 6, 7:    write_words_in_use(bmap_pkg::CNT_W'($urandom_range(1, 8)));
        default:    write_words_in_use(bmap_pkg::CNT_W'($urandom_range(0, 256)));
      endcase
      tx_idle = $urandom_range(0, 1);
      rx_idle = $urandom_range(0, 1);
      n = active_words();
      case ($urandom_range(0, 3))
        0: run_mixed(40);
        1, 2: run_alloc_free(40);
        default: begin
          if (n <= 16) run_fill();
          else run_mixed(40);
        end
      endcase
    end
  endtask

  // long receiver hold-off, counted here
  always begin : stall_hold
    @(hold_kick);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : result_check
    int stall;
    alloc_result_t want;
    @(posedge rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        if (rx_on) begin
          rx_ready <= 1'b0;
          rx_on = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      if (!rx_on) begin
        rx_ready <= 1'b1;
        rx_on = 1'b1;
      end
      do @(posedge clk); while (!(out_valid && out_ready));
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (res_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_status);
          err_cnt++;
        end
        if (res_found !== want.found_bit) begin
          $error("found_bit: expected %0d, got %0d", want.found_bit, res_found);
          err_cnt++;
        end
        if (res_bitval !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, res_bitval);
          err_cnt++;
        end
        if (res_ones !== want.ones_count) begin
          $error("ones_count: expected %0d, got %0d", want.ones_count, res_ones);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #25_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_bitmap();
    test_bit_ops();
    test_spare_modes();
    test_no_words();
    test_one_word_full();
    test_clamped_size();
    test_output_stall();
    test_random_traffic(1480);
    wait_idle();
    repeat (300) @(posedge clk);
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
